@@ hw/rtl/fixed_point_q24_8_alu_assert.svh @@
// Assertion macros for the fixed-point ALU checker
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define FPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpa check failed");
// Next-cycle implication checked outside reset
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpa check failed");
`endif

@@ hw/rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes and shared item types of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_MIN = 4'd4, OP_MAX = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
    OP_TOI = 4'd8, OP_FRI = 4'd9
  } op_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             is_div;
    logic             dz;
    logic             lt;
    logic             eq;
    logic             gt;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } cls_t;

  // Finished result item
  typedef struct packed {
    logic [WordW-1:0] res;
    logic             lt;
    logic             eq;
    logic             gt;
    logic             dz;
  } res_t;
endpackage
`default_nettype wire

@@ hw/rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Accepts items, compares operands and flags divides, registers the item.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [OpW-1:0]   op,
  input  wire logic [WordW-1:0] a,
  input  wire logic [WordW-1:0] b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output cls_t             out_item
);
  logic valid;
  cls_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item.op     <= op;
      item.is_div <= (op == OP_DIV);
      item.dz     <= (op == OP_DIV) && (b == '0);
      item.lt     <= $signed(a) < $signed(b);
      item.eq     <= a == b;
      item.gt     <= $signed(a) > $signed(b);
      item.a      <= a;
      item.b      <= b;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fpa_queue.sv @@
// ----------------------------------------------------------------------------
// fpa_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_queue import fpa_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cls_t in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output cls_t      out_item
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  cls_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic push_q, pop_q;

  assign in_ready  = cnt != (AW+1)'(Depth);
  assign out_valid = cnt != '0;
  assign out_item  = mem[rp];
  assign push_q    = in_valid && in_ready;
  assign pop_q     = out_valid && out_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push_q) begin
        wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      end
      if (pop_q) begin
        rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push_q) - (AW+1)'(pop_q);
    end
    if (push_q) begin
      mem[wp] <= in_item;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fpa_divider.sv @@
// ----------------------------------------------------------------------------
// fpa_divider
// Pipelined signed restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_divider import fpa_pkg::*; #(
  parameter int unsigned FracBits = 8
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WordW-1:0] a,
  input  wire logic [WordW-1:0] b,
  output logic [WordW-1:0]      q
);
  localparam int unsigned NW = WordW + FracBits;
  localparam int unsigned NS = NW + 1;

  logic [NW-1:0]    num   [NS];
  logic [WordW:0]   rem   [NS];
  logic [WordW-1:0] den   [NS];
  logic             neg   [NS];
  logic [NW-1:0]    na;
  logic [WordW-1:0] nb;

  always_comb begin
    na = {{FracBits{1'b0}}, a[WordW-1] ? (~a + 1'b1) : a} << FracBits;
    nb = b[WordW-1] ? (~b + 1'b1) : b;
  end

  // Stage zero: magnitudes and sign
  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= na;
      rem[0] <= '0;
      den[0] <= nb;
      neg[0] <= a[WordW-1] ^ b[WordW-1];
    end
  end

  // One quotient bit per stage; quotient bits shift into num
  for (genvar i = 1; i < NS; i++) begin : g_st
    logic [WordW:0] t;
    logic           ge;
    always_comb begin
      t  = {rem[i-1][WordW-1:0], num[i-1][NW-1]};
      ge = t >= {1'b0, den[i-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? t - {1'b0, den[i-1]} : t;
        num[i] <= {num[i-1][NW-2:0], ge};
        den[i] <= den[i-1];
        neg[i] <= neg[i-1];
      end
    end
  end

  assign q = neg[NS-1] ? (~num[NS-1][WordW-1:0] + 1'b1) : num[NS-1][WordW-1:0];
endmodule
`default_nettype wire

@@ hw/rtl/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// Executes classified items in a lock-step pipeline with an output skid queue.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_back import fpa_pkg::*; #(
  parameter int unsigned FracBits = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cls_t in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_item
);
  // One input stage plus one stage per quotient bit, matching the divider
  localparam int unsigned Lat  = WordW + FracBits + 1;
  localparam int unsigned QD   = 2;
  localparam int unsigned QAW  = $clog2(QD);

  logic       adv;
  logic [Lat-1:0] vpipe;
  res_t       s1, sp [Lat];
  logic [2*WordW-1:0] prod;
  logic       s1div;
  logic       pdiv [Lat];
  logic [WordW-1:0] q;
  res_t       fin;
  logic [QAW:0] cnt;
  logic [QAW-1:0] wp, rp;
  res_t       rq [QD];
  logic       push_r, pop_r;

  // Hold the whole pipeline while its last item cannot enter the full queue
  assign adv      = !(vpipe[Lat-1] && (cnt == (QAW+1)'(QD)));
  assign in_ready = adv;

  // Stage one: simple operations and the product
  always_ff @(posedge clk) begin
    logic [WordW-1:0] r;
    r = '0;
    unique case (in_item.op)
      OP_ADD: r = in_item.a + in_item.b;
      OP_SUB: r = in_item.a - in_item.b;
      OP_MIN: r = in_item.lt ? in_item.a : in_item.b;
      OP_MAX: r = in_item.gt ? in_item.a : in_item.b;
      OP_INC: r = in_item.a + 1'b1;
      OP_DEC: r = in_item.a - 1'b1;
      OP_TOI: r = WordW'($signed(in_item.a) >>> FracBits);
      OP_FRI: r = in_item.a << FracBits;
      default: r = '0;
    endcase
    if (adv) begin
      s1.res <= r;
      s1.lt  <= in_item.lt;
      s1.eq  <= in_item.eq;
      s1.gt  <= in_item.gt;
      s1.dz  <= in_item.dz;
      s1div  <= in_item.is_div && !in_item.dz;
      prod   <= (in_item.op == OP_MUL)
                ? 64'($signed(in_item.a) * $signed(in_item.b)) : '0;
      sp[0]  <= '0;
      pdiv[0] <= 1'b0;
    end
  end

  // Stage two: finish multiply; then delay to match the divider
  always_ff @(posedge clk) begin
    res_t st;
    st = s1;
    if (prod != '0) begin
      st.res = prod[FracBits +: WordW];
    end
    if (adv) begin
      sp[1]   <= st;
      pdiv[1] <= s1div;
    end
  end
  for (genvar i = 2; i < Lat; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (adv) begin
        sp[i]   <= sp[i-1];
        pdiv[i] <= pdiv[i-1];
      end
    end
  end

  fpa_divider #(.FracBits(FracBits)) u_div (
    .clk (clk), .en (adv), .a (in_item.a), .b (in_item.b), .q (q)
  );

  always_comb begin
    fin = sp[Lat-1];
    if (pdiv[Lat-1]) begin
      fin.res = q;
    end
  end

  // Track valid items through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[Lat-2:0], in_valid};
    end
  end

  assign push_r    = adv && vpipe[Lat-1];
  assign pop_r     = out_valid && out_ready;
  assign out_valid = cnt != '0;
  assign out_item  = rq[rp];

  // Result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push_r) wp <= (wp == QAW'(QD-1)) ? '0 : wp + 1'b1;
      if (pop_r)  rp <= (rp == QAW'(QD-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (QAW+1)'(push_r) - (QAW+1)'(pop_r);
    end
    if (push_r) rq[wp] <= fin;
  end
endmodule
`default_nettype wire

@@ hw/rtl/fixed_point_q24_8_alu.sv @@
// Signed Q24.8 fixed-point ALU. Takes one item per cycle while full is low;
// each result passes through the front register and its queue, then the
// bit-per-stage divide pipeline, and waits in a two-entry result queue. The
// execution pipeline stalls as a whole while that queue is full and its last
// stage holds an item; full rises once the front and its queue have filled
// behind the stall.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Top level: front classifier, item queue, execution back end.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_q24_8_alu import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [3:0]  operation,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic             empty,
  input  wire logic        pop,
  output logic signed [31:0] result,
  output logic             a_less,
  output logic             a_equal,
  output logic             a_greater,
  output logic             divide_by_zero
);
  logic fr_ready, f_v, f_r, q_v, q_r, b_v;
  cls_t f_item, q_item;
  res_t r_item;

  assign full = !fr_ready;

  fpa_front u_front (
    .clk, .rst, .in_valid (push), .in_ready (fr_ready), .op (operation),
    .a (operand_a), .b (operand_b),
    .out_valid (f_v), .out_ready (f_r), .out_item (f_item)
  );

  fpa_queue #(.Depth(2)) u_queue (
    .clk, .rst, .in_valid (f_v), .in_ready (f_r), .in_item (f_item),
    .out_valid (q_v), .out_ready (q_r), .out_item (q_item)
  );

  fpa_back #(.FracBits(FRAC_BITS)) u_back (
    .clk, .rst, .in_valid (q_v), .in_ready (q_r), .in_item (q_item),
    .out_valid (b_v), .out_ready (pop), .out_item (r_item)
  );

  assign empty          = !b_v;
  assign result         = r_item.res;
  assign a_less         = r_item.lt;
  assign a_equal        = r_item.eq;
  assign a_greater      = r_item.gt;
  assign divide_by_zero = r_item.dz;
endmodule
`default_nettype wire

@@ hw/rtl/fpa_checker.sv @@
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on results and result flags of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_q24_8_alu_assert.svh"
module fpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] result,
  input wire logic        a_less,
  input wire logic        a_equal,
  input wire logic        a_greater,
  input wire logic        divide_by_zero
);
  `FPA_ASSERT_IMP(a_flags_onehot, !empty, $onehot({a_less, a_equal, a_greater}))
  `FPA_ASSERT_IMP(a_dz_zero, !empty && divide_by_zero, result == '0)
  `FPA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))
endmodule
bind fixed_point_q24_8_alu fpa_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/fixed_point_q24_8_alu_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb
// Self-checking bench for the Q24.8 fixed-point ALU. A directed table covers
// operand extremes, every operation, zero and overflowing divides and unused
// codes; random items follow. Every result is compared with a local model.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_q24_8_alu_tb;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  localparam int N_RANDOM = 1700;
  localparam int LATENCY = FRAC + 35;

  // One item's worth of result fields
  typedef struct {
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
  } alu_out_t;

  // One row of the directed table; has_exp marks rows with a typed-in result
  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          has_exp;
    logic [31:0] exp_res;
    bit          exp_dz;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [3:0] operation = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic full, empty, a_less, a_equal, a_greater, divide_by_zero;
  logic signed [31:0] result;

  alu_out_t awaited_q[$];
  int  errors = 0;
  bit  quiet = 1'b0;        // no random idling while set
  bit  hold_pop = 1'b0;     // long hold-off on the result side
  bit  stim_done = 1'b0;

  fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .operand_a(operand_a), .operand_b(operand_b), .empty(empty), .pop(pop),
    .result(result), .a_less(a_less), .a_equal(a_equal),
    .a_greater(a_greater), .divide_by_zero(divide_by_zero)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Compute the expected result fields of one item
  function automatic alu_out_t alu_predict(logic [3:0] op, logic [31:0] a,
                                           logic [31:0] b);
    alu_out_t o;
    logic signed [63:0] sa, sb, prod, quot;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    o.res = '0;
    o.dz = 1'b0;
    case (op)
      OP_ADD: o.res = a + b;
      OP_SUB: o.res = a - b;
      OP_MUL: begin
        prod = sa * sb;
        o.res = 32'(prod >>> FRAC);
      end
      OP_DIV: begin
        if (b == '0) begin
          o.dz = 1'b1;
        end else begin
          quot = (sa <<< FRAC) / sb;
          o.res = quot[31:0];
        end
      end
      OP_MIN: o.res = (sa < sb) ? a : b;
      OP_MAX: o.res = (sa > sb) ? a : b;
      OP_INC: o.res = a + 32'd1;
      OP_DEC: o.res = a - 32'd1;
      OP_TOI: o.res = 32'(sa >>> FRAC);
      OP_FRI: o.res = a << FRAC;
      default: o.res = '0;
    endcase
    o.lt = sa < sb;
    o.eq = sa == sb;
    o.gt = sa > sb;
    return o;
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    while (!quiet && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    awaited_q.push_back(alu_predict(op, a, b));
    @(negedge clk);
  endtask

  // Draw an operand biased towards the edges of the range
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom_range(512) - 256;
      3: return 32'($urandom_range(16)) << FRAC;
      default: return $urandom;
    endcase
  endfunction

  // Directed table, then random items
  initial begin
    vec_t dir[$];
    vec_t v;
    alu_out_t chk;
    logic [3:0] op;
    logic [31:0] a, b;
    dir = '{
      '{OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1, 32'h8000_0000, 0},
      '{OP_SUB, 32'h8000_0000, 32'h0000_0001, 1, 32'h7FFF_FFFF, 0},
      '{OP_MUL, 32'h0000_0100, 32'h0000_0100, 1, 32'h0000_0100, 0},
      '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0, 0},
      '{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 1, 32'hFFFF_FFFF, 0},
      '{OP_DIV, 32'h0000_0100, 32'h0000_0000, 1, 32'h0000_0000, 1},
      '{OP_DIV, 32'h8000_0000, 32'h0000_0000, 1, 32'h0000_0000, 1},
      '{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, '0, 0},
      '{OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 0, '0, 0},
      '{OP_DIV, 32'hFFFF_FF00, 32'h0000_0300, 0, '0, 0},
      '{OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000, 0},
      '{OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0},
      '{OP_MIN, 32'h0000_1234, 32'h0000_1234, 1, 32'h0000_1234, 0},
      '{OP_INC, 32'h7FFF_FFFF, 32'h0000_0000, 1, 32'h8000_0000, 0},
      '{OP_DEC, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 0},
      '{OP_TOI, 32'hFFFF_FFFF, 32'h0000_0000, 1, 32'hFFFF_FFFF, 0},
      '{OP_TOI, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h007F_FFFF, 0},
      '{OP_FRI, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FF00, 0},
      '{OP_FRI, 32'hFFFF_FFFF, 32'h0000_0005, 1, 32'hFFFF_FF00, 0},
      '{4'd10,  32'h0000_0005, 32'h0000_0009, 1, 32'h0000_0000, 0},
      '{4'd15,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0000, 0},
      '{4'd12,  32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 0}
    };
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (dir[i]) begin
      v = dir[i];
      // Cross-check typed-in rows against the model
      chk = alu_predict(v.op, v.a, v.b);
      if (v.has_exp && (chk.res !== v.exp_res || chk.dz !== v.exp_dz)) begin
        errors++;
        if (errors <= 10) $display("table row %0d disagrees with model", i);
      end
      send_item(v.op, v.a, v.b);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 300 && n < 500);
      if (n == 600) hold_pop = 1'b1;
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                     : 4'($urandom_range(9));
      a = pick_operand();
      b = ($urandom_range(9) == 0) ? 32'h0 : pick_operand();
      if ($urandom_range(9) == 0) b = a;
      send_item(op, a, b);
    end
    push <= 1'b0;
    hold_pop = 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls, plus one long hold-off
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_pop) begin
        pop <= 1'b0;
        stall = 0;
        while (stall < 200) begin
          @(negedge clk);
          stall++;
        end
        hold_pop = 1'b0;
      end
      pop <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && pop && !empty) begin
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing awaited: %h", result);
      end else begin
        e = awaited_q.pop_front();
        if (result !== e.res || a_less !== e.lt || a_equal !== e.eq ||
            a_greater !== e.gt || divide_by_zero !== e.dz) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h lt%b eq%b gt%b dz%b, got %h lt%b eq%b gt%b dz%b",
                     e.res, e.lt, e.eq, e.gt, e.dz, result, a_less, a_equal,
                     a_greater, divide_by_zero);
        end
      end
    end
  end

  // Drain, settle, report
  initial begin
    wait (stim_done);
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && awaited_q.size() == 0) begin
      $display("** fixed_point_q24_8_alu: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu: FAILED **");
    end
    $finish;
  end

  // Guard against a hung run
  initial begin
    #5ms;
    $display("** fixed_point_q24_8_alu: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_queue.sv
hw/rtl/fpa_divider.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_q24_8_alu.sv
hw/rtl/fpa_checker.sv
tb/sv/fixed_point_q24_8_alu_tb.sv
